/* sv/permuted_index_sequencer_top_macros.svh */
// Assertion macros used by the permuted index sequencer datapath.
`ifndef PERMUTED_INDEX_SEQUENCER_TOP_MACROS_SVH
`define PERMUTED_INDEX_SEQUENCER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define PIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define PIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/pis_pkg.sv */
// Types and constants of the permuted index sequencer.
`default_nettype none

package pis_pkg;

    localparam int LEN_W      = 11;
    localparam int ENTRY_W    = 10;
    localparam int WORD_W     = 31;
    localparam int MODE_W     = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int DCNT_W     = $clog2(WORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_WORD    = 2'd1,
        OP_NEXT    = 2'd2,
        OP_SEEK    = 2'd3
    } t_op;

    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_DIV,
        S_CHECK,
        S_RD_P,
        S_RD_J,
        S_WR_P,
        S_WR_J,
        S_NEXT_RD,
        S_NEXT_OUT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic fill;
        logic div_step;
        logic reject;
        logic rd_p;
        logic rd_j;
        logic wr_p;
        logic wr_j;
        logic take_idx;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic shuffling;
        logic cur_at_end;
        logic len_zero;
        logic fill_last;
        logic div_last;
        logic word_ok;
    } t_stat;

endpackage

`default_nettype wire

/* sv/pis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pis_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/pis_ctrl.sv */
// Controller state machine of the permuted index sequencer.
`default_nettype none

module pis_ctrl
    import pis_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [OP_W-1:0] i_operation,
    input  wire t_stat           i_stat,
    output t_cmd                 o_cmd,
    output logic                 o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (t_op'(i_operation))
                        OP_RESTART: n_state = i_stat.len_zero ? S_FINISH : S_FILL;
                        OP_WORD:    n_state = i_stat.shuffling ? S_DIV : S_FINISH;
                        OP_NEXT: begin
                            if (i_stat.shuffling || i_stat.cur_at_end) begin
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_NEXT_RD;
                            end
                        end
                        OP_SEEK:    n_state = S_FINISH;
                    endcase
                end
            end
            S_FILL: begin
                if (i_stat.fill_last) begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK:    n_state = i_stat.word_ok ? S_RD_P : S_FINISH;
            S_RD_P:     n_state = S_RD_J;
            S_RD_J:     n_state = S_WR_P;
            S_WR_P:     n_state = S_WR_J;
            S_WR_J:     n_state = S_FINISH;
            S_NEXT_RD:  n_state = S_NEXT_OUT;
            S_NEXT_OUT: n_state = S_FINISH;
            S_FINISH:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:     o_cmd.load     = i_start;
            S_FILL:     o_cmd.fill     = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_CHECK:    o_cmd.reject   = !i_stat.word_ok;
            S_RD_P:     o_cmd.rd_p     = 1'b1;
            S_RD_J:     o_cmd.rd_j     = 1'b1;
            S_WR_P:     o_cmd.wr_p     = 1'b1;
            S_WR_J:     o_cmd.wr_j     = 1'b1;
            S_NEXT_OUT: o_cmd.take_idx = 1'b1;
            S_FINISH:   o_cmd.emit     = 1'b1;
            default:    o_cmd          = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* sv/pis_dp.sv */
// Datapath: configuration, cursor, shuffle divider, order table and result registers.
`default_nettype none
`include "permuted_index_sequencer_top_macros.svh"

module pis_dp
    import pis_pkg::*;
#(
    parameter int MAX_LENGTH = 1024,
    parameter int RANDOM_MAX = 2147483647
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [LEN_W-1:0]      i_seek_position,
    input  wire logic [WORD_W-1:0]     i_random_word,
    output logic                       o_done,
    output logic [ENTRY_W-1:0]         o_element_index,
    output logic                       o_index_valid,
    output logic                       o_exhausted,
    output logic                       o_shuffle_busy,
    output logic                       o_word_rejected
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int NW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (AW > LEN_W) ? AW : LEN_W;

    // configuration and control state
    logic [LEN_W-1:0]  r_seq_length;
    logic [MODE_W-1:0] r_order_mode;
    logic [LEN_W-1:0]  r_cursor;
    logic [AW-1:0]     r_pos;
    logic              r_shuffling;

    // work registers
    logic [AW-1:0]     r_fill_cnt;
    logic [WORD_W-1:0] r_dw;
    logic [NW-1:0]     r_rw;
    logic [WORD_W-1:0] r_dr;
    logic [NW-1:0]     r_rr;
    logic [DCNT_W-1:0] r_dcnt;
    logic [ENTRY_W-1:0] r_tp;
    logic [ENTRY_W-1:0] r_idx;
    logic              r_valid;
    logic              r_exh;
    logic              r_rej;

    // result registers
    logic              r_done;
    logic [ENTRY_W-1:0] r_o_idx;
    logic              r_o_valid;
    logic              r_o_exh;
    logic              r_o_busy;
    logic              r_o_rej;

    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_len_m1;
    logic [NW-1:0]      w_n;
    logic [AW-1:0]      w_j;
    logic [NW:0]        w_tw;
    logic [NW:0]        w_tr;
    logic               w_gew;
    logic               w_ger;
    logic [ENTRY_W-1:0] w_fill_val;
    logic               w_ram_we;
    logic [AW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;

    assign w_len = (32'(r_seq_length) > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_seq_length;
    assign w_len_m1 = w_len - LEN_W'(1);
    assign w_n = NW'(r_pos) + NW'(1);
    assign w_j = AW'(r_rw);

    // one restoring step for the word and for the rejection bound, same divisor
    assign w_tw  = {r_rw, r_dw[WORD_W-1]};
    assign w_tr  = {r_rr, r_dr[WORD_W-1]};
    assign w_gew = (w_tw >= {1'b0, w_n});
    assign w_ger = (w_tr >= {1'b0, w_n});

    assign w_fill_val = (r_order_mode == MODE_REVERSE)
                      ? ENTRY_W'(CW'(w_len_m1) - CW'(r_fill_cnt))
                      : ENTRY_W'(r_fill_cnt);

    assign o_stat.shuffling  = r_shuffling;
    assign o_stat.cur_at_end = (r_cursor >= w_len);
    assign o_stat.len_zero   = (w_len == '0);
    assign o_stat.fill_last  = (CW'(r_fill_cnt) == CW'(w_len_m1));
    assign o_stat.div_last   = (r_dcnt == '0);
    // accept when the word quotient is below the bound quotient
    assign o_stat.word_ok    = (r_dw < r_dr);

    always_comb begin
        w_ram_we = i_cmd.fill || i_cmd.wr_p || i_cmd.wr_j;
        priority if (i_cmd.fill) begin
            w_waddr = r_fill_cnt;
            w_wdata = w_fill_val;
        end else if (i_cmd.wr_p) begin
            w_waddr = r_pos;
            w_wdata = w_rdata;
        end else begin
            w_waddr = w_j;
            w_wdata = r_tp;
        end
        priority if (i_cmd.rd_p) begin
            w_raddr = r_pos;
        end else if (i_cmd.rd_j) begin
            w_raddr = w_j;
        end else begin
            w_raddr = AW'(r_cursor);
        end
    end

    pis_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LENGTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length <= '0;
            r_order_mode <= '0;
            r_cursor     <= '0;
            r_pos        <= '0;
            r_shuffling  <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SEQ_LENGTH: r_seq_length <= LEN_W'(i_cfg_wdata);
                    CFG_ORDER_MODE: r_order_mode <= MODE_W'(i_cfg_wdata);
                endcase
            end
            if (i_cmd.load) begin
                unique case (t_op'(i_operation))
                    OP_RESTART: begin
                        r_cursor <= '0;
                        if (r_order_mode == MODE_RANDOM && w_len > LEN_W'(1)) begin
                            r_pos       <= AW'(w_len_m1);
                            r_shuffling <= 1'b1;
                        end else begin
                            r_pos       <= '0;
                            r_shuffling <= 1'b0;
                        end
                    end
                    OP_SEEK: begin
                        r_cursor <= (i_seek_position > w_len) ? w_len : i_seek_position;
                    end
                    OP_WORD, OP_NEXT: begin
                    end
                endcase
            end
            if (i_cmd.take_idx) begin
                r_cursor <= r_cursor + LEN_W'(1);
            end
            // step down after the swap; the last position ends the shuffle
            if (i_cmd.wr_j) begin
                r_pos <= r_pos - AW'(1);
                if (r_pos == AW'(1)) begin
                    r_shuffling <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fill_cnt <= '0;
            r_dw       <= i_random_word;
            r_rw       <= '0;
            r_dr       <= WORD_W'(RANDOM_MAX);
            r_rr       <= '0;
            r_dcnt     <= DCNT_W'(WORD_W - 1);
            r_idx      <= '0;
            r_valid    <= 1'b0;
            r_rej      <= 1'b0;
            r_exh      <= (t_op'(i_operation) == OP_NEXT) && !r_shuffling
                          && (r_cursor >= w_len);
        end
        if (i_cmd.fill) begin
            r_fill_cnt <= r_fill_cnt + AW'(1);
        end
        if (i_cmd.div_step) begin
            r_rw   <= w_gew ? NW'(w_tw - {1'b0, w_n}) : NW'(w_tw);
            r_dw   <= {r_dw[WORD_W-2:0], w_gew};
            r_rr   <= w_ger ? NW'(w_tr - {1'b0, w_n}) : NW'(w_tr);
            r_dr   <= {r_dr[WORD_W-2:0], w_ger};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
        if (i_cmd.reject) begin
            r_rej <= 1'b1;
        end
        if (i_cmd.rd_j) begin
            r_tp <= w_rdata;
        end
        if (i_cmd.take_idx) begin
            r_idx   <= w_rdata;
            r_valid <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_idx   <= r_idx;
            r_o_valid <= r_valid;
            r_o_exh   <= r_exh;
            r_o_busy  <= r_shuffling;
            r_o_rej   <= r_rej;
        end
    end

    assign o_done          = r_done;
    assign o_element_index = r_o_idx;
    assign o_index_valid   = r_o_valid;
    assign o_exhausted     = r_o_exh;
    assign o_shuffle_busy  = r_o_busy;
    assign o_word_rejected = r_o_rej;

    `PIS_ASSERT_IMP(a_pos_live, i_clk, i_rst_n, r_shuffling, r_pos != '0, "shuffle at position zero")
    `PIS_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, i_cmd.div_step, r_rw < w_n, "remainder out of range")
    `PIS_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, i_cmd.fill, CW'(r_fill_cnt) < CW'(w_len), "fill past length")
    `PIS_ASSERT_NXT(a_pos_step, i_clk, i_rst_n, i_cmd.wr_j, r_pos == $past(r_pos) - AW'(1), "position did not step")

endmodule

`default_nettype wire

/* sv/permuted_index_sequencer_top.sv */
// Top level of the permuted index sequencer: controller, datapath and order table.
//
// Usage: write seq_length (index 0) and order_mode (index 1) through the
// i_cfg_we / i_cfg_addr / i_cfg_wdata port while the block is idle, then issue
// commands with i_start while o_busy is low. Each command transfer produces
// exactly one result, shown for a single cycle with o_done high.
// Path of each command from transfer to its o_done cycle:
//   seek, idle random word, blocked or exhausted next: straight to the result
//   next that returns an index: a registered table read, then the result
//   restart: one table entry written per cycle for the L entries
//   random word during a shuffle: the serial divider computes word mod n and
//   the bound quotient, then, unless the word is rejected, the swap takes
//   four table accesses through the single read and single write port.
// A new command may be issued in the cycle in which o_done is high.
// Reset clears configuration, cursor and shuffle state; table contents stay
// undefined until a restart writes them. The receiver cannot stall: results
// must be taken in their o_done cycle.
`default_nettype none

module permuted_index_sequencer_top
    import pis_pkg::*;
#(
    parameter int MAX_LENGTH = 1024,
    parameter int RANDOM_MAX = 2147483647
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [LEN_W-1:0]      i_seek_position,
    input  wire logic [WORD_W-1:0]     i_random_word,
    output logic                       o_done,
    output logic [ENTRY_W-1:0]         o_element_index,
    output logic                       o_index_valid,
    output logic                       o_exhausted,
    output logic                       o_shuffle_busy,
    output logic                       o_word_rejected
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy)
    );

    pis_dp #(
        .MAX_LENGTH (MAX_LENGTH),
        .RANDOM_MAX (RANDOM_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_seek_position (i_seek_position),
        .i_random_word   (i_random_word),
        .o_done          (o_done),
        .o_element_index (o_element_index),
        .o_index_valid   (o_index_valid),
        .o_exhausted     (o_exhausted),
        .o_shuffle_busy  (o_shuffle_busy),
        .o_word_rejected (o_word_rejected)
    );

endmodule

`default_nettype wire
